### src/kts_pkg.sv
// kts_pkg: shared types, note tables and sine table helper for the key to tone synthesizer
`timescale 1ns / 1ps
package kts_pkg;

   // note table: key byte, frequency in Hz, hold length in ms
   localparam int NOTE_COUNT = 40;

   localparam logic [7:0] NOTE_KEY [NOTE_COUNT] = '{
      8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h30, 8'h2d, 8'h3d,
      8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69, 8'h6f, 8'h70, 8'h5b, 8'h5d,
      8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5e, 8'h26, 8'h2a, 8'h28, 8'h29, 8'h5f, 8'h2b,
      8'h51, 8'h57, 8'h45, 8'h52
   };

   localparam logic [12:0] NOTE_HZ [NOTE_COUNT] = '{
      13'd440,  13'd466,  13'd494,  13'd523,  13'd554,  13'd587,
      13'd622,  13'd659,  13'd698,  13'd740,  13'd784,  13'd831,
      13'd880,  13'd932,  13'd988,  13'd1047, 13'd1109, 13'd1175,
      13'd1245, 13'd1319, 13'd1397, 13'd1480, 13'd1568, 13'd1661,
      13'd1760, 13'd1865, 13'd1980, 13'd2093, 13'd2218, 13'd2349,
      13'd2489, 13'd2637, 13'd2794, 13'd2960, 13'd3136, 13'd3322,
      13'd3520, 13'd3729, 13'd3951, 13'd4186
   };

   localparam logic [8:0] NOTE_HOLD_MS [NOTE_COUNT] = '{
      9'd360, 9'd357, 9'd353, 9'd350, 9'd347, 9'd344, 9'd341, 9'd338, 9'd334, 9'd330,
      9'd327, 9'd323, 9'd320, 9'd318, 9'd316, 9'd314, 9'd312, 9'd310, 9'd308, 9'd306,
      9'd304, 9'd302, 9'd300, 9'd298, 9'd296, 9'd294, 9'd292, 9'd290, 9'd288, 9'd286,
      9'd284, 9'd282, 9'd280, 9'd278, 9'd276, 9'd274, 9'd272, 9'd270, 9'd268, 9'd266
   };

   // longest hold, used to size the tick counters
   localparam int MAX_HOLD_MS = 360;

   // q30 and q15 fixed point constants for the sine polynomial
   localparam logic [63:0] Q30_ONE     = 64'd1073741824;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [63:0] Q15_ROUND   = 64'd16384;
   localparam logic [63:0] Q15_ONE     = 64'd32768;

   // configuration register map
   localparam int CSR_ADDR_BITS = 3;
   localparam logic CSR_AMPLITUDE = 1'b0;
   localparam logic [14:0] AMPLITUDE_RESET = 15'd700;

   // result queue
   localparam int RESULT_FIFO_DEPTH = 8;
   localparam int FIFO_PTR_BITS = $clog2(RESULT_FIFO_DEPTH);
   localparam int FIFO_CNT_BITS = $clog2(RESULT_FIFO_DEPTH + 1);

   typedef struct packed {
      logic signed [15:0] sample_value;
      logic               sample_valid;
      logic [7:0]         echo_code;
      logic               echo_valid;
   } rsp_item_type;

   // sine of a q30 angle in [0, pi/2] as q15, taylor series, rounded half up, capped at 1.0
   function automatic logic [15:0] q15_sine(input logic [63:0] x);
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] s;
      x2 = (x * x) >> 30;
      t  = Q30_ONE - x2 / 64'd110;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
      s  = (x * t) >> 30;
      s  = (s + Q15_ROUND) >> 15;
      if (s > Q15_ONE) begin
         s = Q15_ONE;
      end
      return s[15:0];
   endfunction

endpackage

### src/kts_if.sv
// kts_req_if and kts_rsp_if: request and result channels of the key to tone synthesizer
`timescale 1ns / 1ps
interface kts_req_if;
   logic       valid;
   logic       ready;
   logic       command;
   logic [7:0] key_code;

   modport source (output valid, output command, output key_code, input ready);
   modport sink (input valid, input command, input key_code, output ready);
endinterface

interface kts_rsp_if;
   logic              valid;
   logic              ready;
   logic signed [15:0] sample_value;
   logic              sample_valid;
   logic [7:0]        echo_code;
   logic              echo_valid;

   modport source (output valid, output sample_value, output sample_valid,
                   output echo_code, output echo_valid, input ready);
   modport sink (input valid, input sample_value, input sample_valid,
                 input echo_code, input echo_valid, output ready);
endinterface

### src/kts_result_fifo.sv
// kts_result_fifo: result queue between the synthesis pipeline and the result channel
`timescale 1ns / 1ps
module kts_result_fifo
   import kts_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         wr_en,
   input  rsp_item_type wr_item,
   kts_rsp_if.source    rsp_if
);

   rsp_item_type              mem_ff [RESULT_FIFO_DEPTH];
   logic [FIFO_PTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_BITS-1:0]  count_ff, count_in;
   logic                      pop;
   rsp_item_type              head;

   assign pop  = rsp_if.valid && rsp_if.ready;
   assign head = mem_ff[rd_ptr_ff];

   assign rsp_if.valid        = (count_ff != '0);
   assign rsp_if.sample_value = head.sample_value;
   assign rsp_if.sample_valid = head.sample_valid;
   assign rsp_if.echo_code    = head.echo_code;
   assign rsp_if.echo_valid   = head.echo_valid;

   always_comb begin
      wr_ptr_in = wr_en ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (!wr_en && pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= wr_item;
      end
   end

endmodule

### src/key_to_tone_synthesizer.sv
// key_to_tone_synthesizer: key byte driven sine tone generator with an apb register port
// path: a result passes stages a, b and c and the result queue before rsp_if offers it
// throughput: one request per cycle while req_if.ready is high; the note state updates in
// the accept cycle; sine lookup, scaling and sign run in a free-running pipeline into an
// 8-entry result queue; req_if.ready drops only when 8 results are in flight or queued
// reset: synchronous, clears the pipeline and queue, amplitude 700, tone silent
`timescale 1ns / 1ps
module key_to_tone_synthesizer
   import kts_pkg::*;
#(
   parameter int SINE_TABLE_DEPTH = 256,
   parameter int PHASE_BITS       = 32,
   parameter int TICK_RATE_HZ     = 10000
) (
   input  logic                     clock,
   input  logic                     reset,
   kts_req_if.sink                  req_if,
   kts_rsp_if.source                rsp_if,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [31:0]              pwdata,
   output logic [31:0]              prdata,
   output logic                     pready
);

   // quarter-wave table holds QUARTER+1 entries, index 0..QUARTER
   localparam int QUARTER   = SINE_TABLE_DEPTH / 4;
   localparam int IDX_BITS  = $clog2(QUARTER + 1);
   localparam int REST_BITS = PHASE_BITS - 2;
   localparam int PROD_BITS = REST_BITS + IDX_BITS;
   // elapsed ticks run one past the longest hold before the tone goes silent
   localparam int MAX_HOLD  = (MAX_HOLD_MS * TICK_RATE_HZ + 500) / 1000;
   localparam int HOLD_BITS = $clog2(MAX_HOLD + 2);

   // ---------------------------------------------------------------------------------
   // constant tables: per-note phase step and hold, and the quarter sine table
   // ---------------------------------------------------------------------------------
   logic [PHASE_BITS-1:0] step_tbl [NOTE_COUNT];
   logic [HOLD_BITS-1:0]  hold_tbl [NOTE_COUNT];
   logic [15:0]           sine_tbl [QUARTER+1];

   for (genvar n = 0; n < NOTE_COUNT; n++) begin : g_note
      // step = freq * 2^PHASE_BITS / tick rate, halves rounded up
      localparam logic [63:0] STEP_FULL =
         ((64'(NOTE_HZ[n]) << PHASE_BITS) + 64'(TICK_RATE_HZ / 2)) / 64'(TICK_RATE_HZ);
      localparam logic [63:0] HOLD_FULL =
         (64'(NOTE_HOLD_MS[n]) * 64'(TICK_RATE_HZ) + 64'd500) / 64'd1000;
      assign step_tbl[n] = STEP_FULL[PHASE_BITS-1:0];
      assign hold_tbl[n] = HOLD_FULL[HOLD_BITS-1:0];
   end

   for (genvar i = 0; i <= QUARTER; i++) begin : g_sine
      localparam logic [63:0] ANGLE = (64'(i) * HALF_PI_Q30) / 64'(QUARTER);
      assign sine_tbl[i] = q15_sine(ANGLE);
   end

   // ---------------------------------------------------------------------------------
   // configuration port
   // ---------------------------------------------------------------------------------
   logic [14:0] amplitude_ff, amplitude_in;
   logic        csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign prdata    = (paddr[2] == CSR_AMPLITUDE) ? {17'b0, amplitude_ff} : 32'b0;

   always_comb begin
      amplitude_in = amplitude_ff;
      if (csr_write && paddr[2] == CSR_AMPLITUDE) begin
         amplitude_in = pwdata[14:0];
      end
   end

   // ---------------------------------------------------------------------------------
   // note state, updated in the cycle a request is accepted
   // ---------------------------------------------------------------------------------
   logic [PHASE_BITS-1:0] phase_acc_ff, phase_acc_in;
   logic [PHASE_BITS-1:0] phase_step_ff, phase_step_in;
   logic [HOLD_BITS-1:0]  hold_length_ff, hold_length_in;
   logic [HOLD_BITS-1:0]  elapsed_ff, elapsed_in;
   logic                  silent_ff, silent_in;

   logic                  accept;
   logic                  key_hit;
   logic [PHASE_BITS-1:0] key_step;
   logic [HOLD_BITS-1:0]  key_hold;
   logic                  is_tick;
   logic                  has_result;
   logic [PROD_BITS-1:0]  phase_prod;

   assign accept  = req_if.valid && req_if.ready;
   assign is_tick = req_if.command;

   // key lookup: keys in the table are distinct
   always_comb begin
      key_hit  = 1'b0;
      key_step = '0;
      key_hold = '0;
      for (int n = 0; n < NOTE_COUNT; n++) begin
         if (req_if.key_code == NOTE_KEY[n]) begin
            key_hit  = 1'b1;
            key_step = step_tbl[n];
            key_hold = hold_tbl[n];
         end
      end
   end

   assign has_result = is_tick || key_hit;

   always_comb begin
      phase_acc_in   = phase_acc_ff;
      phase_step_in  = phase_step_ff;
      hold_length_in = hold_length_ff;
      elapsed_in     = elapsed_ff;
      silent_in      = silent_ff;
      if (accept) begin
         if (is_tick) begin
            if (!silent_ff) begin
               elapsed_in = elapsed_ff + 1'b1;
               if (elapsed_in > hold_length_ff) begin
                  silent_in = 1'b1;
               end
            end
            // phase advances only while the tone is still sounding
            if (!silent_in) begin
               phase_acc_in = phase_acc_ff + phase_step_ff;
            end
         end else if (key_hit) begin
            // restart the note with the new key
            phase_acc_in   = '0;
            phase_step_in  = key_step;
            hold_length_in = key_hold;
            elapsed_in     = '0;
            silent_in      = 1'b0;
         end
      end
   end

   // table index before mirroring: low phase bits scaled to the quarter table
   assign phase_prod = PROD_BITS'(phase_acc_ff[REST_BITS-1:0]) * PROD_BITS'(QUARTER);

   // ---------------------------------------------------------------------------------
   // stage a: quadrant and index, stage b: table read, stage c: amplitude scaling
   // ---------------------------------------------------------------------------------
   logic                a_valid_ff, b_valid_ff, c_valid_ff;
   logic                a_tick_ff, b_tick_ff, c_tick_ff;
   logic                a_zero_ff, b_zero_ff, c_zero_ff;
   logic [1:0]          a_quad_ff;
   logic                b_neg_ff, c_neg_ff;
   logic [IDX_BITS-1:0] a_index_ff;
   logic [7:0]          a_echo_ff, b_echo_ff, c_echo_ff;
   logic [15:0]         b_entry_ff;
   logic [15:0]         c_mag_ff;

   logic [IDX_BITS-1:0] rom_addr;
   logic [30:0]         scaled;
   rsp_item_type        out_item;

   // quadrants 1 and 3 run the table backwards
   assign rom_addr = a_quad_ff[0] ? IDX_BITS'(QUARTER) - a_index_ff : a_index_ff;
   assign scaled   = 31'(amplitude_ff) * 31'(b_entry_ff);

   always_comb begin
      out_item.sample_valid = c_tick_ff;
      out_item.echo_valid   = !c_tick_ff;
      out_item.echo_code    = c_tick_ff ? 8'h00 : c_echo_ff;
      if (c_zero_ff) begin
         out_item.sample_value = 16'sd0;
      end else if (c_neg_ff) begin
         out_item.sample_value = -$signed(c_mag_ff);
      end else begin
         out_item.sample_value = $signed(c_mag_ff);
      end
   end

   // ---------------------------------------------------------------------------------
   // credits: results accepted and not yet delivered never exceed the queue depth
   // ---------------------------------------------------------------------------------
   logic [FIFO_CNT_BITS-1:0] credit_ff, credit_in;
   logic                     credit_take;
   logic                     credit_give;

   assign credit_take  = accept && has_result;
   assign credit_give  = rsp_if.valid && rsp_if.ready;
   assign req_if.ready = (credit_ff < FIFO_CNT_BITS'(RESULT_FIFO_DEPTH));

   always_comb begin
      credit_in = credit_ff;
      if (credit_take && !credit_give) begin
         credit_in = credit_ff + 1'b1;
      end else if (!credit_take && credit_give) begin
         credit_in = credit_ff - 1'b1;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         amplitude_ff   <= AMPLITUDE_RESET;
         phase_acc_ff   <= '0;
         phase_step_ff  <= '0;
         hold_length_ff <= '0;
         elapsed_ff     <= '0;
         silent_ff      <= 1'b1;
         credit_ff      <= '0;
         a_valid_ff     <= 1'b0;
         b_valid_ff     <= 1'b0;
         c_valid_ff     <= 1'b0;
      end else begin
         amplitude_ff   <= amplitude_in;
         phase_acc_ff   <= phase_acc_in;
         phase_step_ff  <= phase_step_in;
         hold_length_ff <= hold_length_in;
         elapsed_ff     <= elapsed_in;
         silent_ff      <= silent_in;
         credit_ff      <= credit_in;
         a_valid_ff     <= credit_take;
         b_valid_ff     <= a_valid_ff;
         c_valid_ff     <= b_valid_ff;
      end
   end

   // pipeline payload, free running
   always_ff @(posedge clock) begin
      // stage a: sample uses the phase before this tick's advance
      a_tick_ff  <= is_tick;
      a_zero_ff  <= !is_tick || silent_in;
      a_quad_ff  <= phase_acc_ff[PHASE_BITS-1 -: 2];
      a_index_ff <= phase_prod[PROD_BITS-1 -: IDX_BITS];
      a_echo_ff  <= req_if.key_code;
      // stage b: registered table read
      b_tick_ff  <= a_tick_ff;
      b_zero_ff  <= a_zero_ff;
      b_neg_ff   <= a_quad_ff[1];
      b_entry_ff <= sine_tbl[rom_addr];
      b_echo_ff  <= a_echo_ff;
      // stage c: magnitude truncated toward zero
      c_tick_ff  <= b_tick_ff;
      c_zero_ff  <= b_zero_ff;
      c_neg_ff   <= b_neg_ff;
      c_mag_ff   <= scaled[30:15];
      c_echo_ff  <= b_echo_ff;
   end

   kts_result_fifo u_result_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (c_valid_ff),
      .wr_item (out_item),
      .rsp_if  (rsp_if)
   );

endmodule

### src/kts_checker.sv
// kts_checker: port-level assertions for the key to tone synthesizer, with its bind
`timescale 1ns / 1ps
module kts_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic signed [15:0] rsp_sample_value,
   input logic              rsp_sample_valid,
   input logic              rsp_echo_valid
);

   // a waiting result is not withdrawn
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn while stalled");

   // every result is either a sample or an echo, never both
   a_rsp_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_sample_valid ^ rsp_echo_valid))
      else $error("result is not exactly one of sample or echo");

   // echoes carry a zero sample
   a_echo_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_echo_valid |-> rsp_sample_value == 16'sd0)
      else $error("echo result with nonzero sample");

   // scaled magnitude never reaches full negative scale
   a_sample_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_sample_valid |-> rsp_sample_value != -16'sd32768)
      else $error("sample out of range");

   // the result queue is empty right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result offered right after reset");

endmodule

bind key_to_tone_synthesizer kts_checker u_kts_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_if.valid),
   .rsp_ready        (rsp_if.ready),
   .rsp_sample_value (rsp_if.sample_value),
   .rsp_sample_valid (rsp_if.sample_valid),
   .rsp_echo_valid   (rsp_if.echo_valid)
);
